[src/lzwc_pkg.sv]
// Shared constants, types and helpers of the LZW compress encoder.
package lzwc_pkg;

    localparam int unsigned MAX_CODE_BITS = 16;
    localparam logic [31:0] CHECK_GAP     = 32'd10000;
    localparam int unsigned HASH_SHIFT    = 8;
    localparam int unsigned EPOCH_W       = 4;
    localparam int unsigned KEY_W         = 24;
    localparam int unsigned CODE_W        = 16;
    localparam int unsigned NFC_W         = 17;
    localparam int unsigned GROUP_BYTES   = 16;
    localparam int unsigned QDEPTH        = 4;

    localparam logic [15:0] CODE_CLEAR    = 16'd256;
    localparam logic [16:0] CODE_FIRST    = 17'd257;
    localparam logic [16:0] LIMIT_START   = 17'd511;
    localparam logic [4:0]  WIDTH_START   = 5'd9;
    localparam logic [7:0]  MAGIC_0       = 8'h1F;
    localparam logic [7:0]  MAGIC_1       = 8'h9D;
    localparam logic [31:0] RATIO_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] BIG_INPUT     = 32'h007F_FFFF;

    // one unit of work for the packer
    typedef struct packed {
        logic        raw;        // code[7:0] is a literal stream byte
        logic        last_b;     // last byte of the beat sequence ends the stream
        logic [15:0] code;
        logic [7:0]  bitpos;
        logic [4:0]  cw;
        logic [4:0]  flush_len;
    } t_cmd;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [KEY_W-1:0]   key;
        logic [CODE_W-1:0]  code;
    } t_hent;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

[src/lzwc_ifs.sv]
// Valid/ready channel interfaces of the LZW compress encoder.
interface lzwc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;
    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lzwc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       final_byte;
    modport source (output valid, output out_byte, output final_byte, input ready);
    modport sink   (input valid, input out_byte, input final_byte, output ready);
endinterface

interface lzwc_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] max_bits;
    modport source (output valid, output max_bits, input ready);
    modport sink   (input valid, input max_bits, output ready);
endinterface

[src/lzwc_front.sv]
// Front end: takes input bytes, probes the hash table, issues packer commands.
module lzwc_front #(
    parameter int unsigned HASH_SIZE = 69001
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lzwc_in_if.sink        i_in,
    lzwc_cfg_if.sink       i_cfg,
    output logic           o_cmd_valid,
    output lzwc_pkg::t_cmd o_cmd,
    input  logic           i_cmd_ready
);
    import lzwc_pkg::*;

    localparam int unsigned IDX_W = $clog2(HASH_SIZE);
    localparam logic [IDX_W:0]   HS    = (IDX_W+1)'(HASH_SIZE);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(HASH_SIZE - 1);

    typedef enum logic [9:0] {
        S_SWEEP = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_HDR   = 10'b00_0000_0100,
        S_PROBE = 10'b00_0000_1000,
        S_CMP   = 10'b00_0001_0000,
        S_MISS  = 10'b00_0010_0000,
        S_DIV   = 10'b00_0100_0000,
        S_RAT   = 10'b00_1000_0000,
        S_CLR   = 10'b01_0000_0000,
        S_EOS   = 10'b10_0000_0000
    } t_fstate;

    t_fstate r_state, n_state;
    logic [4:0]  r_maxb, r_sb, n_sb;
    logic [15:0] r_prefix, n_prefix;
    logic [16:0] r_nfc, n_nfc, r_wlim, n_wlim;
    logic [4:0]  r_cw, n_cw;
    logic [7:0]  r_bitpos, n_bitpos;
    logic [31:0] r_bin, n_bin, r_bw, n_bw, r_nchk, n_nchk, r_best, n_best;
    logic        r_clrp, n_clrp, r_started, n_started;
    logic [7:0]  r_c, n_c;
    logic        r_eos, n_eos;
    logic [23:0] r_fcode, n_fcode;
    logic [IDX_W-1:0] r_idx, n_idx, r_swidx, n_swidx;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic        r_sweep_req, n_sweep_req;
    logic [1:0]  r_hcnt, n_hcnt;
    logic [31:0] r_rem, n_rem, r_num, n_num, r_den, n_den, r_quo, n_quo;
    logic [4:0]  r_dcnt, n_dcnt;

    t_hent r_mem [HASH_SIZE];
    t_hent r_rdata, mem_wdata;
    logic [IDX_W-1:0] mem_addr;
    logic  mem_we;

    // put_code datapath
    logic [15:0] pc_code;
    logic        pc_eos, pc_full, pc_grow;
    logic [7:0]  pc_bp_new;
    logic [8:0]  pc_part;
    logic [4:0]  pc_flen, pc_cw1;
    logic [31:0] pc_bw;
    t_cmd        pc_cmd;

    // misc
    logic        push, accept, hit, occupied, insert;
    logic [4:0]  clamp_b;
    logic [IDX_W:0] i_ext, disp, nxt;
    logic [32:0] dv_t;
    logic        dv_ge;
    logic [31:0] rt_den;
    logic [EPOCH_W-1:0] epoch_inc;
    t_fstate     after_item;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && (r_state == S_IDLE);

    always_comb begin
        clamp_b = r_maxb;
        if (clamp_b == 5'd0 || clamp_b > 5'(MAX_CODE_BITS)) begin
            clamp_b = 5'(MAX_CODE_BITS);
        end
        if (clamp_b < WIDTH_START) begin
            clamp_b = WIDTH_START;
        end
    end

    always_comb begin
        pc_code   = (r_state == S_CLR) ? CODE_CLEAR : r_prefix;
        pc_eos    = (r_state == S_EOS);
        pc_bp_new = r_bitpos + {3'b000, r_cw};
        pc_full   = (pc_bp_new == {r_cw, 3'b000});
        pc_grow   = (r_nfc > r_wlim) || r_clrp;
        pc_part   = ({1'b0, pc_bp_new} + 9'd7) >> 3;
        if (pc_full || pc_grow) begin
            pc_flen = r_cw;
        end else if (pc_eos) begin
            pc_flen = pc_part[4:0];
        end else begin
            pc_flen = 5'd0;
        end
        pc_bw  = sat_add32(r_bw, {27'd0, pc_flen});
        pc_cw1 = r_cw + 5'd1;
        pc_cmd = '{raw: 1'b0, last_b: pc_eos, code: pc_code, bitpos: r_bitpos,
                   cw: r_cw, flush_len: pc_flen};
    end

    always_comb begin
        i_ext = {1'b0, r_idx};
        disp  = (r_idx == '0) ? (IDX_W+1)'(1) : HS - i_ext;
        nxt   = (i_ext >= disp) ? i_ext - disp : i_ext + HS - disp;
    end

    assign occupied  = (r_rdata.epoch == r_epoch);
    assign hit       = occupied && (r_rdata.key == r_fcode);
    assign insert    = (r_nfc < (17'd1 << r_sb));
    assign epoch_inc = r_epoch + EPOCH_W'(1);
    assign dv_t      = {r_rem, r_num[31]};
    assign dv_ge     = (dv_t >= {1'b0, r_den});
    assign rt_den    = (r_bin > BIG_INPUT) ? (pc_bw >> 8) : pc_bw;

    always_comb begin
        if (r_eos) begin
            after_item = S_EOS;
        end else if (r_sweep_req) begin
            after_item = S_SWEEP;
        end else begin
            after_item = S_IDLE;
        end
    end

    always_comb begin
        o_cmd_valid = (r_state == S_HDR) || (r_state == S_MISS) ||
                      (r_state == S_CLR) || (r_state == S_EOS);
        o_cmd = pc_cmd;
        if (r_state == S_HDR) begin
            o_cmd.raw       = 1'b1;
            o_cmd.last_b    = 1'b0;
            o_cmd.flush_len = 5'd1;
            case (r_hcnt)
                2'd0:    o_cmd.code = {8'd0, MAGIC_0};
                2'd1:    o_cmd.code = {8'd0, MAGIC_1};
                default: o_cmd.code = {8'd0, 8'h80 | {3'b000, r_sb}};
            endcase
        end
    end
    assign push = o_cmd_valid && i_cmd_ready;

    always_comb begin
        mem_addr  = (r_state == S_SWEEP) ? r_swidx : r_idx;
        mem_we    = (r_state == S_SWEEP) || ((r_state == S_MISS) && push && insert);
        mem_wdata = (r_state == S_SWEEP) ? t_hent'('0) :
                    t_hent'{epoch: r_epoch, key: r_fcode, code: r_nfc[15:0]};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    always_comb begin
        n_state = r_state;   n_sb = r_sb;       n_prefix = r_prefix;
        n_nfc = r_nfc;       n_wlim = r_wlim;   n_cw = r_cw;
        n_bitpos = r_bitpos; n_bin = r_bin;     n_bw = r_bw;
        n_nchk = r_nchk;     n_best = r_best;   n_clrp = r_clrp;
        n_started = r_started; n_c = r_c;       n_eos = r_eos;
        n_fcode = r_fcode;   n_idx = r_idx;     n_swidx = r_swidx;
        n_epoch = r_epoch;   n_sweep_req = r_sweep_req; n_hcnt = r_hcnt;
        n_rem = r_rem;       n_num = r_num;     n_den = r_den;
        n_quo = r_quo;       n_dcnt = r_dcnt;

        // packing state follows every code command
        if (push && (r_state != S_HDR)) begin
            n_bw = pc_bw;
            n_bitpos = (pc_full || pc_grow || pc_eos) ? 8'd0 : pc_bp_new;
            if (pc_grow) begin
                if (r_clrp) begin
                    n_cw = WIDTH_START;
                    n_wlim = LIMIT_START;
                    n_clrp = 1'b0;
                end else begin
                    n_cw = pc_cw1;
                    n_wlim = (pc_cw1 == r_sb) ? (17'd1 << r_sb) : ((17'd1 << pc_cw1) - 17'd1);
                end
            end
        end

        unique case (r_state)
            S_SWEEP: begin
                n_swidx = r_swidx + IDX_W'(1);
                if (r_swidx == LAST) begin
                    n_swidx = '0;
                    n_sweep_req = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_c   = i_in.data_byte;
                    n_eos = i_in.end_of_stream;
                    if (!r_started) begin
                        n_sb = clamp_b;
                        n_started = 1'b1;
                        n_bitpos = 8'd0;
                        n_bw = 32'd3;
                        n_clrp = 1'b0;
                        n_best = 32'd0;
                        n_bin = 32'd1;
                        n_nchk = CHECK_GAP;
                        n_cw = WIDTH_START;
                        n_wlim = LIMIT_START;
                        n_nfc = CODE_FIRST;
                        n_prefix = {8'd0, i_in.data_byte};
                        n_hcnt = 2'd0;
                        n_epoch = (epoch_inc == '0) ? EPOCH_W'(1) : epoch_inc;
                        n_sweep_req = (epoch_inc == '0);
                        n_state = S_HDR;
                    end else begin
                        n_bin = sat_add32(r_bin, 32'd1);
                        n_fcode = (24'(i_in.data_byte) << r_sb) | 24'(r_prefix);
                        n_idx = IDX_W'(({i_in.data_byte, 8'd0} >> (8 - HASH_SHIFT)) ^ r_prefix);
                        n_state = S_PROBE;
                    end
                end
            end
            S_HDR: begin
                if (push) begin
                    n_hcnt = r_hcnt + 2'd1;
                    if (r_hcnt == 2'd2) begin
                        n_state = after_item;
                    end
                end
            end
            S_PROBE: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    n_prefix = r_rdata.code;
                    n_state = after_item;
                end else if (!occupied) begin
                    n_state = S_MISS;
                end else begin
                    n_idx = nxt[IDX_W-1:0];
                    n_state = S_PROBE;
                end
            end
            S_MISS: begin
                if (push) begin
                    n_prefix = {8'd0, r_c};
                    n_state = after_item;
                    if (insert) begin
                        n_nfc = r_nfc + 17'd1;
                    end else if (r_bin >= r_nchk) begin
                        n_nchk = sat_add32(r_bin, CHECK_GAP);
                        n_rem = 32'd0;
                        n_quo = 32'd0;
                        n_dcnt = 5'd0;
                        if (rt_den == 32'd0) begin
                            n_num = RATIO_MAX;
                            n_den = 32'd1;
                        end else begin
                            n_num = (r_bin > BIG_INPUT) ? r_bin : (r_bin << 8);
                            n_den = rt_den;
                        end
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem = dv_ge ? 32'(dv_t - {1'b0, r_den}) : dv_t[31:0];
                n_quo = {r_quo[30:0], dv_ge};
                n_num = r_num << 1;
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) begin
                    n_state = S_RAT;
                end
            end
            S_RAT: begin
                if (r_quo > r_best) begin
                    n_best = r_quo;
                    n_state = after_item;
                end else begin
                    n_best = 32'd0;
                    n_nfc = CODE_FIRST;
                    n_clrp = 1'b1;
                    n_epoch = (epoch_inc == '0) ? EPOCH_W'(1) : epoch_inc;
                    n_sweep_req = (epoch_inc == '0);
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                if (push) begin
                    n_state = after_item;
                end
            end
            S_EOS: begin
                if (push) begin
                    n_started = 1'b0;
                    n_eos = 1'b0;
                    n_state = r_sweep_req ? S_SWEEP : S_IDLE;
                end
            end
            default: n_state = S_SWEEP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_maxb <= 5'd16;
            r_sb <= 5'd16;
            r_prefix <= '0;
            r_nfc <= CODE_FIRST;
            r_wlim <= LIMIT_START;
            r_cw <= WIDTH_START;
            r_bitpos <= '0;
            r_bin <= 32'd1;
            r_bw <= 32'd3;
            r_nchk <= CHECK_GAP;
            r_best <= '0;
            r_clrp <= 1'b0;
            r_started <= 1'b0;
            r_eos <= 1'b0;
            r_swidx <= '0;
            r_epoch <= EPOCH_W'(1);
            r_sweep_req <= 1'b0;
            r_hcnt <= '0;
            r_dcnt <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_maxb <= i_cfg.max_bits;
            end
            r_sb <= n_sb;
            r_prefix <= n_prefix;
            r_nfc <= n_nfc;
            r_wlim <= n_wlim;
            r_cw <= n_cw;
            r_bitpos <= n_bitpos;
            r_bin <= n_bin;
            r_bw <= n_bw;
            r_nchk <= n_nchk;
            r_best <= n_best;
            r_clrp <= n_clrp;
            r_started <= n_started;
            r_eos <= n_eos;
            r_swidx <= n_swidx;
            r_epoch <= n_epoch;
            r_sweep_req <= n_sweep_req;
            r_hcnt <= n_hcnt;
            r_dcnt <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
        r_fcode <= n_fcode;
        r_idx <= n_idx;
        r_rem <= n_rem;
        r_num <= n_num;
        r_den <= n_den;
        r_quo <= n_quo;
    end

endmodule

[src/lzwc_cmd_fifo.sv]
// Short command queue between the front end and the packer.
module lzwc_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  lzwc_pkg::t_cmd i_push,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output lzwc_pkg::t_cmd o_pop,
    input  logic           i_pop_ready
);
    import lzwc_pkg::*;

    localparam int unsigned PTR_W = $clog2(QDEPTH);

    t_cmd r_q [QDEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W:0]   r_cnt;
    logic do_push, do_pop;

    assign o_push_ready = (r_cnt != (PTR_W+1)'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop        = r_q[r_rp];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            r_cnt <= r_cnt + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
    end

endmodule

[src/lzwc_back.sv]
// Packer: merges codes into the group buffer and sends out bytes one beat at a time.
module lzwc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  lzwc_pkg::t_cmd i_cmd,
    output logic           o_cmd_ready,
    lzwc_out_if.source     o_out
);
    import lzwc_pkg::*;

    logic [7:0] r_grp [GROUP_BYTES];
    logic       r_busy, r_raw, r_last, r_ov, r_of;
    logic [7:0] r_rawb, r_ob;
    logic [4:0] r_cnt, r_len;
    logic       can_emit, take;
    logic [3:0] byte0;
    logic [2:0] sh;
    logic [23:0] v;
    logic [4:0] nbytes;
    logic [4:0] cnt_inc;

    assign can_emit    = !r_ov || o_out.ready;
    assign o_cmd_ready = !r_busy;
    assign take        = i_cmd_valid && !r_busy;
    assign cnt_inc     = r_cnt + 5'd1;

    assign byte0  = i_cmd.bitpos[6:3];
    assign sh     = i_cmd.bitpos[2:0];
    assign v      = 24'(i_cmd.code) << sh;
    assign nbytes = 5'(({2'b00, sh} + i_cmd.cw + 5'd7) >> 3);

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_ob;
    assign o_out.final_byte = r_of;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < GROUP_BYTES; j++) begin
                r_grp[j] <= 8'd0;
            end
        end else if (take && !i_cmd.raw) begin
            for (int j = 0; j < GROUP_BYTES; j++) begin
                logic [3:0] off;
                off = 4'(j) - byte0;
                if (off == 4'd0) begin
                    r_grp[j] <= (r_grp[j] & ((8'd1 << sh) - 8'd1)) | v[7:0];
                end else if (off == 4'd1 && nbytes > 5'd1) begin
                    r_grp[j] <= v[15:8];
                end else if (off == 4'd2 && nbytes > 5'd2) begin
                    r_grp[j] <= v[23:16];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_raw  <= i_cmd.raw;
            r_rawb <= i_cmd.code[7:0];
            r_last <= i_cmd.last_b;
            r_len  <= i_cmd.flush_len;
        end
        if (r_busy && can_emit) begin
            r_ob <= r_raw ? r_rawb : r_grp[r_cnt[3:0]];
            r_of <= r_last && (cnt_inc == r_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (r_busy && can_emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (take) begin
                r_busy <= (i_cmd.flush_len != 5'd0);
                r_cnt  <= '0;
            end else if (r_busy && can_emit) begin
                r_cnt <= cnt_inc;
                if (cnt_inc == r_len) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

[src/lzw_compress_encoder.sv]
// Top level of the LZW compress (.Z) stream encoder.
//
// Channels: i_in carries one uncompressed byte per beat with end_of_stream on
// the last byte of a stream; o_out carries the compressed stream one byte per
// beat, final_byte marking its last byte; i_cfg writes max_bits at any time and
// the value is taken when the next stream starts.
// Flow: the front end holds one input byte at a time. A byte that hits on the
// first hash probe goes through a probe and a compare; each further probe adds
// one registered read of the single-port table memory and one compare; a miss
// adds a state that issues the code; a ratio check adds a bit-serial divider.
// The first byte of a stream issues the header; the last byte also issues a flush.
// The packer sends one byte per cycle from its group buffer while o_out.ready
// holds, decoupled from the front end by a four-entry command queue.
// Reset: all HASH_SIZE entries of the table memory are swept with i_in.ready low;
// the same sweep follows every fifteenth table clear. Tables are otherwise
// cleared by advancing an epoch tag.
// Stall: a held output byte stays put; the queue then fills and the front end
// stops taking input until room frees up.
module lzw_compress_encoder_unit #(
    parameter int unsigned HASH_SIZE = 69001
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lzwc_in_if.sink   i_in,
    lzwc_cfg_if.sink  i_cfg,
    lzwc_out_if.source o_out
);
    import lzwc_pkg::*;

    logic f_valid, f_ready, b_valid, b_ready;
    t_cmd f_cmd, b_cmd;

    lzwc_front #(.HASH_SIZE(HASH_SIZE)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .o_cmd_valid (f_valid),
        .o_cmd       (f_cmd),
        .i_cmd_ready (f_ready)
    );

    lzwc_cmd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .i_push       (f_cmd),
        .o_push_ready (f_ready),
        .o_pop_valid  (b_valid),
        .o_pop        (b_cmd),
        .i_pop_ready  (b_ready)
    );

    lzwc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (b_valid),
        .i_cmd       (b_cmd),
        .o_cmd_ready (b_ready),
        .o_out       (o_out)
    );

endmodule

[src/lzwc_checker.sv]
// Port-level checks of the LZW compress encoder, bound to the top level.
module lzwc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_final
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) &&
        $stable(i_out_final))
        else $error("output beat changed while stalled");

    // one byte in flight in the front end
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken on back-to-back cycles");

    // the table sweep runs after reset
    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind lzw_compress_encoder_unit lzwc_checker u_lzwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_final (o_out.final_byte)
);

[tb/lzw_compress_encoder_unit_test.sv]
// Self-checking testbench of the LZW compress encoder: random streams against a built-in predictor.
module lzw_compress_encoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lzwc_pkg::*;

    localparam int unsigned TBL_SIZE  = 69001;
    localparam logic [24:0] KEY_EMPTY = 25'h100_0000;
    localparam int unsigned SETTLE    = 60;

    typedef struct {
        logic [7:0] data;
        logic       eos;
    } t_in_item;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_out_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lzwc_in_if  in_ch ();
    lzwc_cfg_if cfg_ch ();
    lzwc_out_if out_ch ();

    lzw_compress_encoder_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [24:0] tbl_key  [TBL_SIZE];
    logic [15:0] tbl_code [TBL_SIZE];
    logic [7:0]  grp [16];
    logic [4:0]  width_reg;
    logic [31:0] stream_bits, prefix, next_code, cw, limit_code, bitpos;
    logic [31:0] n_in, n_written, next_check, best_ratio;
    logic        clear_pend, in_stream;

    t_out_item   step_bytes [$];
    t_out_item   expected_bytes [$];
    t_in_item    pending_bytes [$];
    int          n_errors = 0;
    logic        burst_mode = 1'b0;

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void emit(logic [7:0] b);
        t_out_item o;
        o.data = b;
        o.last = 1'b0;
        if (step_bytes.size() < 64) step_bytes.push_back(o);
    endfunction

    function automatic void emit_group(logic [31:0] len);
        for (int k = 0; k < len && k < 16; k++) emit(grp[k]);
        n_written = add_sat(n_written, len);
    endfunction

    function automatic void wipe_table();
        for (int k = 0; k < TBL_SIZE; k++) tbl_key[k] = KEY_EMPTY;
    endfunction

    function automatic void pack_code(logic [31:0] code);
        logic [31:0] byte0, r, v, nb;
        byte0 = (bitpos >> 3) & 15;
        r     = bitpos & 7;
        v     = (code & 32'hFFFF) << r;
        nb    = (r + cw + 7) >> 3;
        grp[byte0] = (grp[byte0] & 8'((32'd1 << r) - 1)) | v[7:0];
        for (int k = 1; k < nb && k < 4; k++)
            grp[(byte0 + k) & 15] = 8'(v >> (8 * k));
        bitpos = bitpos + cw;
        if (bitpos == (cw << 3)) begin
            emit_group(cw);
            bitpos = 0;
        end
        if (next_code > limit_code || clear_pend) begin
            if (bitpos > 0) emit_group(cw);
            bitpos = 0;
            if (clear_pend) begin
                cw = 9;
                limit_code = 511;
                clear_pend = 1'b0;
            end else begin
                cw = cw + 1;
                if (cw == stream_bits) limit_code = 32'd1 << stream_bits;
                else limit_code = (32'd1 << cw[4:0]) - 1;
            end
        end
    endfunction

    function automatic void check_ratio();
        logic [31:0] rat;
        next_check = add_sat(n_in, CHECK_GAP);
        if (n_in > BIG_INPUT) begin
            rat = n_written >> 8;
            rat = (rat == 0) ? RATIO_MAX : n_in / rat;
        end else begin
            rat = (n_written != 0) ? (n_in << 8) / n_written : RATIO_MAX;
        end
        if (rat > best_ratio) begin
            best_ratio = rat;
        end else begin
            best_ratio = 0;
            wipe_table();
            next_code = CODE_FIRST;
            clear_pend = 1'b1;
            pack_code(CODE_CLEAR);
        end
    endfunction

    function automatic void extend_prefix(logic [31:0] c);
        logic [31:0] fkey, idx, disp;
        fkey = (c << stream_bits) + prefix;
        idx  = ((c << HASH_SHIFT) ^ prefix) % TBL_SIZE;
        n_in = add_sat(n_in, 1);
        if (tbl_key[idx] == fkey[24:0]) begin
            prefix = tbl_code[idx];
            return;
        end
        if (tbl_key[idx] != KEY_EMPTY) begin
            disp = (idx == 0) ? 1 : TBL_SIZE - idx;
            for (int n = 0; n < TBL_SIZE; n++) begin
                idx = (idx >= disp) ? idx - disp : idx + TBL_SIZE - disp;
                if (tbl_key[idx] == fkey[24:0]) begin
                    prefix = tbl_code[idx];
                    return;
                end
                if (tbl_key[idx] == KEY_EMPTY) break;
            end
        end
        pack_code(prefix);
        prefix = c;
        if (next_code < (32'd1 << stream_bits)) begin
            tbl_code[idx] = next_code[15:0];
            tbl_key[idx]  = fkey[24:0];
            next_code = next_code + 1;
        end else if (n_in >= next_check) begin
            check_ratio();
        end
    endfunction

    function automatic void encode_byte(t_in_item it);
        logic [31:0] b;
        step_bytes.delete();
        if (!in_stream) begin
            b = width_reg;
            if (b == 0 || b > MAX_CODE_BITS) b = MAX_CODE_BITS;
            if (b < 9) b = 9;
            stream_bits = b;
            in_stream = 1'b1;
            emit(MAGIC_0);
            emit(MAGIC_1);
            emit(8'(b | 32'h80));
            bitpos = 0;
            n_written = 3;
            clear_pend = 1'b0;
            best_ratio = 0;
            n_in = 1;
            next_check = CHECK_GAP;
            cw = 9;
            limit_code = 511;
            next_code = CODE_FIRST;
            prefix = it.data;
            wipe_table();
        end else begin
            extend_prefix(it.data);
        end
        if (it.eos) begin
            pack_code(prefix);
            if (bitpos > 0) emit_group((bitpos + 7) >> 3);
            bitpos = 0;
            in_stream = 1'b0;
            if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
        end
        foreach (step_bytes[k]) expected_bytes.push_back(step_bytes[k]);
    endfunction

    // input driver
    int in_gap = 0;
    always @(posedge i_clk) begin
        t_in_item it;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                it.data = in_ch.data_byte;
                it.eos  = in_ch.end_of_stream;
                encode_byte(it);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    it = pending_bytes.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.data_byte     <= it.data;
                    in_ch.end_of_stream <= it.eos;
                    in_gap = burst_mode ? 0 : $urandom_range(0, 6);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    int out_stall = 0;
    always @(posedge i_clk) begin
        t_out_item want;
        logic      rdy;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected out_byte 0x%02h", out_ch.out_byte);
                    n_errors++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_ch.out_byte !== want.data) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h", want.data,
                               out_ch.out_byte);
                        n_errors++;
                    end
                    if (out_ch.final_byte !== want.last) begin
                        $error("final_byte: expected %0b, got %0b", want.last,
                               out_ch.final_byte);
                        n_errors++;
                    end
                end
                out_stall = burst_mode ? 0 : $urandom_range(0, 6);
            end
            if (out_stall > 0) begin
                out_stall--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_ch.ready <= rdy;
        end
    end

    task automatic push_byte(logic [7:0] d, logic e);
        t_in_item it;
        it.data = d;
        it.eos  = e;
        pending_bytes.push_back(it);
    endtask

    // small alphabets give long dictionary hits, full range gives misses
    task automatic push_stream(int len, int alpha_lo, int alpha_hi);
        for (int k = 0; k < len; k++)
            push_byte(8'($urandom_range(alpha_lo, alpha_hi)), k == len - 1);
    endtask

    task automatic push_random_streams(int count);
        int len;
        for (int s = 0; s < count; s++) begin
            len = $urandom_range(1, 30);
            case ($urandom_range(0, 2))
                0: push_stream(len, 0, 255);
                1: push_stream(len, 97, 100);
                default: push_stream(len, 0, 1);
            endcase
        end
    endtask

    // hold until the encoder has nothing in flight
    task automatic drain();
        while (pending_bytes.size() > 0 || in_ch.valid || expected_bytes.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_width(logic [4:0] v);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.max_bits <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        width_reg = v;
    endtask

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = 8'd0;
        in_ch.end_of_stream = 1'b0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.max_bits     = 5'd0;
        width_reg  = 5'd16;
        in_stream  = 1'b0;
        foreach (grp[k]) grp[k] = 8'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one-byte streams, extreme bytes, repeats
        write_width(5'd16);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        for (int k = 0; k < 8; k++) push_byte((k % 2) ? 8'hFF : 8'h00, 1'b0);
        for (int k = 0; k < 12; k++) push_byte(8'h41, k == 11);
        drain();

        // smallest width: fill the table so the width steps past nine
        write_width(5'd9);
        push_stream(280, 0, 255);
        push_random_streams(2);
        drain();

        // out of range values, then mid sizes
        write_width(5'd31);
        burst_mode = 1'b1;
        push_random_streams(2);
        drain();
        burst_mode = 1'b0;
        write_width(5'd0);
        push_random_streams(2);
        drain();
        write_width(5'd3);
        push_random_streams(2);
        drain();
        write_width(5'd12);
        push_random_streams(2);
        drain();
        write_width(5'd16);
        push_random_streams(2);
        drain();

        repeat (100) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
